// ===== design/lzssd_pkg.sv =====
// Shared types, constants and codes for the LZSS byte-stream decompressor.
package lzssd_pkg;

  // Default geometry
  localparam int DEF_WINDOW_DEPTH = 4096;
  localparam int DEF_LENGTH_BITS  = 4;

  // Field widths
  localparam int BYTE_W       = 8;
  localparam int STATUS_W     = 2;
  localparam int LEN_BIAS_W   = 2;
  localparam int END_MARKER_W = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 12;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_RUN = 2'd0;
  localparam logic [STATUS_W-1:0] ST_END = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_BIAS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 1'b1;

  // Register reset values and stream constants
  localparam logic [LEN_BIAS_W-1:0]   LEN_BIAS_RST   = 2'd1;
  localparam logic [END_MARKER_W-1:0] END_MARKER_RST = 12'd0;
  localparam logic [BYTE_W-1:0]       FLAG_FIRST     = 8'h80;
  localparam logic [BYTE_W-1:0]       MASK_START     = 8'h40;
  localparam logic [1:0]              PAD_LIMIT      = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic emit_single;
    logic reduce_step;
    logic rd_issue;
    logic emit_copy;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_copy;
    logic need_reduce;
    logic slot_free;
    logic copy_done;
  } dp_stat_t;

endpackage

// ===== design/lzssd_ifs.sv =====
// Channel interfaces: compressed input, decompressed result and configuration write.
interface lzssd_in_if;
  import lzssd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzssd_out_if;
  import lzssd_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                has_byte;
  logic [STATUS_W-1:0] status;
  logic                last;
  modport source (output valid, output out_byte, output has_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input status,
                  input last, output ready);
endinterface

interface lzssd_cfg_if;
  import lzssd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/lzssd_ctrl.sv =====
// Controller state machine: sequences accept, single results, position folding and copy read/write steps.
module lzssd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lzssd_pkg::dp_stat_t  stat,
  output lzssd_pkg::ctrl_cmd_t cmd
);
  import lzssd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EMIT   = 5'b00010,
    S_REDUCE = 5'b00100,
    S_READ   = 5'b01000,
    S_WRITE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.is_copy ? S_REDUCE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit_single = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_REDUCE: begin
        // fold the match position into the window range
        if (stat.need_reduce) begin
          cmd.reduce_step = 1'b1;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_WRITE;
      end
      S_WRITE: begin
        if (stat.slot_free) begin
          cmd.emit_copy = 1'b1;
          state_nxt     = stat.copy_done ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/lzssd_dp.sv =====
// Datapath: parser registers, history window memory, copy counters and result register.
module lzssd_dp #(
  parameter int WINDOW_DEPTH = lzssd_pkg::DEF_WINDOW_DEPTH,
  parameter int LENGTH_BITS  = lzssd_pkg::DEF_LENGTH_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lzssd_pkg::ctrl_cmd_t                cmd,
  output lzssd_pkg::dp_stat_t                 stat,
  input  logic [lzssd_pkg::BYTE_W-1:0]        in_byte,
  input  logic                                in_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lzssd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lzssd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lzssd_pkg::BYTE_W-1:0]        out_byte,
  output logic                                has_byte,
  output logic [lzssd_pkg::STATUS_W-1:0]      status,
  output logic                                last
);
  import lzssd_pkg::*;

  localparam int AW   = $clog2(WINDOW_DEPTH);
  localparam int PW   = 16 - LENGTH_BITS;
  localparam int XW   = ((PW > AW) ? PW : AW) + 1;
  localparam int CW   = LENGTH_BITS + 2;
  localparam int CMPW = (PW > END_MARKER_W) ? PW : END_MARKER_W;

  typedef enum logic [3:0] {
    PH_CONTROL  = 4'b0001,
    PH_LITERAL  = 4'b0010,
    PH_MATCH_HI = 4'b0100,
    PH_MATCH_LO = 4'b1000
  } phase_t;

  function automatic logic [STATUS_W-1:0] status_of(input logic err, input logic ended);
    logic [STATUS_W-1:0] s;
    s = err ? ST_ERR : (ended ? ST_END : ST_RUN);
    return s;
  endfunction

  function automatic phase_t phase_after(input logic [BYTE_W-1:0] flags,
                                         input logic [BYTE_W-1:0] mask);
    phase_t p;
    if (mask == '0) begin
      p = PH_CONTROL;
    end else if ((flags & mask) != '0) begin
      p = PH_LITERAL;
    end else begin
      p = PH_MATCH_HI;
    end
    return p;
  endfunction

  // Configuration registers
  logic [LEN_BIAS_W-1:0]   be_r;
  logic [END_MARKER_W-1:0] em_r;

  // Parser state
  phase_t              phase_r, phase_nxt;
  logic [BYTE_W-1:0]   flag_r, flag_nxt;
  logic [BYTE_W-1:0]   mask_r, mask_nxt;
  logic [BYTE_W-1:0]   mhi_r, mhi_nxt;
  logic                ended_r, ended_nxt;
  logic [1:0]          pad_r, pad_nxt;
  logic                closed_r, closed_nxt;
  logic                err_r, err_nxt;

  // Window write side and fill tracking
  logic [AW-1:0]       wp_r, wp_nxt, wp_inc;
  logic                wrap_r, wrap_nxt;
  logic                full_r, full_nxt;
  logic                mem_we;
  logic [BYTE_W-1:0]   mem_wdata;
  logic [BYTE_W-1:0]   win_mem [WINDOW_DEPTH];

  // Copy state
  logic [XW-1:0]       addr_r, addr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   rd_data_r;
  logic                rd_ok_r;
  logic [AW-1:0]       rd_addr;
  logic                rd_ok;
  logic [BYTE_W-1:0]   copy_byte;

  // Pending single result
  logic [BYTE_W-1:0]   res_byte_r, res_byte_nxt;
  logic                res_has_r, res_has_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;

  // Result register
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                has_byte_r;
  logic [STATUS_W-1:0] status_r;
  logic                last_r;

  // Match word fields
  logic [15:0]         word;
  logic [PW-1:0]       mpos;
  logic                at_end;

  assign word   = {mhi_r, in_byte};
  assign mpos   = word[15:LENGTH_BITS];
  assign at_end = (CMPW'(mpos) == CMPW'(em_r));

  assign wp_inc    = (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rd_addr   = addr_r[AW-1:0];
  assign rd_ok     = full_r || ((rd_addr != '0) && (wrap_r || (rd_addr < wp_r)));
  assign copy_byte = rd_ok_r ? rd_data_r : '0;

  // Status toward the controller
  always_comb begin
    stat.is_copy     = !err_r && !ended_r && (phase_r == PH_MATCH_LO) && !at_end;
    stat.need_reduce = (addr_r >= XW'(WINDOW_DEPTH));
    stat.slot_free   = !out_valid_r || out_ready;
    stat.copy_done   = (cnt_r == CW'(1));
  end

  // Parser, window pointer and copy bookkeeping
  always_comb begin
    phase_nxt    = phase_r;
    flag_nxt     = flag_r;
    mask_nxt     = mask_r;
    mhi_nxt      = mhi_r;
    ended_nxt    = ended_r;
    pad_nxt      = pad_r;
    closed_nxt   = closed_r;
    err_nxt      = err_r;
    wp_nxt       = wp_r;
    wrap_nxt     = wrap_r;
    full_nxt     = full_r;
    addr_nxt     = addr_r;
    cnt_nxt      = cnt_r;
    res_byte_nxt = res_byte_r;
    res_has_nxt  = res_has_r;
    res_st_nxt   = res_st_r;
    mem_we       = 1'b0;
    mem_wdata    = in_byte;

    if (cmd.accept) begin
      res_byte_nxt = '0;
      res_has_nxt  = 1'b0;
      if (err_r) begin
        // drop everything once the error is set
      end else if (ended_r) begin
        // allow a little padding in the closing feed
        if (closed_r || (pad_r == PAD_LIMIT)) begin
          err_nxt = 1'b1;
        end else begin
          pad_nxt = pad_r + 1'b1;
        end
        if (in_last) begin
          closed_nxt = 1'b1;
        end
      end else begin
        case (phase_r)
          PH_CONTROL: begin
            flag_nxt  = in_byte;
            mask_nxt  = MASK_START;
            phase_nxt = ((in_byte & FLAG_FIRST) != '0) ? PH_LITERAL : PH_MATCH_HI;
          end
          PH_LITERAL: begin
            mem_we       = 1'b1;
            mem_wdata    = in_byte;
            res_byte_nxt = in_byte;
            res_has_nxt  = 1'b1;
            phase_nxt    = phase_after(flag_r, mask_r);
            mask_nxt     = mask_r >> 1;
          end
          PH_MATCH_HI: begin
            mhi_nxt   = in_byte;
            phase_nxt = PH_MATCH_LO;
          end
          PH_MATCH_LO: begin
            if (at_end) begin
              ended_nxt = 1'b1;
              pad_nxt   = '0;
              if (in_last) begin
                closed_nxt = 1'b1;
              end
            end else begin
              addr_nxt = XW'(mpos);
              cnt_nxt  = CW'(word[LENGTH_BITS-1:0]) + CW'(be_r) + CW'(1);
            end
          end
          default: begin
            phase_nxt = PH_CONTROL;
          end
        endcase
      end
      res_st_nxt = status_of(err_nxt, ended_nxt);
    end

    if (cmd.reduce_step) begin
      addr_nxt = addr_r - XW'(WINDOW_DEPTH);
    end

    if (cmd.emit_copy) begin
      mem_we    = 1'b1;
      mem_wdata = copy_byte;
      cnt_nxt   = cnt_r - 1'b1;
      addr_nxt  = (rd_addr == AW'(WINDOW_DEPTH - 1)) ? '0 : XW'(rd_addr) + XW'(1);
      if (cnt_r == CW'(1)) begin
        phase_nxt = phase_after(flag_r, mask_r);
        mask_nxt  = mask_r >> 1;
      end
    end

    // advance the write pointer and track which entries hold data
    if (mem_we) begin
      wp_nxt = wp_inc;
      if (wp_r == '0) begin
        full_nxt = 1'b1;
      end
      if (wp_r == AW'(WINDOW_DEPTH - 1)) begin
        wrap_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CONTROL;
      flag_r   <= '0;
      mask_r   <= '0;
      mhi_r    <= '0;
      ended_r  <= 1'b0;
      pad_r    <= '0;
      closed_r <= 1'b0;
      err_r    <= 1'b0;
      wp_r     <= AW'(1);
      wrap_r   <= 1'b0;
      full_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      flag_r   <= flag_nxt;
      mask_r   <= mask_nxt;
      mhi_r    <= mhi_nxt;
      ended_r  <= ended_nxt;
      pad_r    <= pad_nxt;
      closed_r <= closed_nxt;
      err_r    <= err_nxt;
      wp_r     <= wp_nxt;
      wrap_r   <= wrap_nxt;
      full_r   <= full_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    res_byte_r <= res_byte_nxt;
    res_has_r  <= res_has_nxt;
    res_st_r   <= res_st_nxt;
  end

  // History window: one write and one registered read, never in the same cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wp_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= win_mem[rd_addr];
      rd_ok_r   <= rd_ok;
    end
  end

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      be_r <= LEN_BIAS_RST;
      em_r <= END_MARKER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEN_BIAS:   be_r <= cfg_data[LEN_BIAS_W-1:0];
        CFG_END_MARKER: em_r <= cfg_data[END_MARKER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result register: load a new item or drop the taken one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_single || cmd.emit_copy) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      out_byte_r <= res_byte_r;
      has_byte_r <= res_has_r;
      status_r   <= res_st_r;
      last_r     <= 1'b1;
    end else if (cmd.emit_copy) begin
      out_byte_r <= copy_byte;
      has_byte_r <= 1'b1;
      status_r   <= status_of(err_r, ended_r);
      last_r     <= (cnt_r == CW'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign has_byte  = has_byte_r;
  assign status    = status_r;
  assign last      = last_r;

endmodule

// ===== design/lzssd_core_top.sv =====
// Top level of the LZSS byte-stream decompressor core.
// One compressed byte is taken per input item. A control byte, the first byte
// of a match word, the end marker or a padding byte yields one result without
// a data byte; a literal yields one result with the byte. These items take an
// accept and then a load of the result register. A match word that copies
// N = length + length bias + 1 bytes first has its match position folded back
// below WINDOW_DEPTH, one step at a time; then every copied byte needs a
// registered read of the single history memory followed by the write of that
// byte at the write position.
// The history window is not swept after reset: entries never written read as
// zero through fill tracking of the write position, so the core takes input
// from the first cycle after reset. The result register lets the next item be
// accepted while the last result still waits. Configuration is always ready
// and must be written only while the core is idle.
module lzss_byte_stream_decompressor_core #(
  parameter int WINDOW_DEPTH = lzssd_pkg::DEF_WINDOW_DEPTH,
  parameter int LENGTH_BITS  = lzssd_pkg::DEF_LENGTH_BITS
) (
  input logic          clk,
  input logic          rst_n,
  lzssd_in_if.sink     in_if,
  lzssd_out_if.source  out_if,
  lzssd_cfg_if.sink    cfg_if
);
  import lzssd_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lzssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzssd_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (in_if.in_byte),
    .in_last   (in_if.in_last),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_byte  (out_if.out_byte),
    .has_byte  (out_if.has_byte),
    .status    (out_if.status),
    .last      (out_if.last)
  );

endmodule

// ===== design/lzssd_checker.sv =====
// Port-level checker for the decompressor core and its bind statement.
module lzssd_port_props (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [lzssd_pkg::BYTE_W-1:0]      out_byte,
  input logic                              has_byte,
  input logic [lzssd_pkg::STATUS_W-1:0]    status,
  input logic                              last
);
  import lzssd_pkg::*;

  logic err_seen_r;

  // Remember that an error result has been delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && out_ready && (status == ST_ERR)) begin
      err_seen_r <= 1'b1;
    end
  end

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last)
      && $stable(has_byte) && $stable(status))
    else $error("result changed while stalled");

  // Data bytes only come from a running stream
  a_byte_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && has_byte |-> (status == ST_RUN))
    else $error("data byte with non-running status");

  // Results without a byte carry zero and the last mark
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_byte |-> (out_byte == '0) && last)
    else $error("empty result malformed");

  // Error status is sticky
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> (status == ST_ERR))
    else $error("error status dropped");

endmodule

bind lzss_byte_stream_decompressor_core lzssd_port_props u_lzssd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_byte  (out_if.out_byte),
  .has_byte  (out_if.has_byte),
  .status    (out_if.status),
  .last      (out_if.last)
);

// ===== tb/lzssd_checker.sv =====
// Watches the decompressor channels, predicts every result and compares it.
module lzssd_checker (
  input  logic clk,
  input  logic rst_n,
  lzssd_in_if  in_mon,
  lzssd_out_if out_mon,
  lzssd_cfg_if cfg_mon,
  output int   fail_count,
  output int   pending
);
  import lzssd_pkg::*;

  localparam int WIN   = DEF_WINDOW_DEPTH;
  localparam int LEN_W = DEF_LENGTH_BITS;
  localparam int POS_W = 16 - LEN_W;

  typedef enum logic [3:0] {
    EXPECT_CTRL = 4'b0001,
    EXPECT_LIT  = 4'b0010,
    EXPECT_MHI  = 4'b0100,
    EXPECT_MLO  = 4'b1000
  } parse_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic                has;
    logic [STATUS_W-1:0] st;
    logic                fin;
  } result_t;

  result_t decoded_q[$];

  // Mirror of the decoder state
  logic [BYTE_W-1:0]       win_mem [WIN];
  logic [POS_W-1:0]        wr_pos;
  parse_t                  phase;
  logic [BYTE_W-1:0]       flags;
  logic [BYTE_W-1:0]       mask;
  logic [BYTE_W-1:0]       hi_byte;
  logic                    ended;
  logic                    closed;
  logic                    err;
  logic [1:0]              pads;
  logic [LEN_BIAS_W-1:0]   be_reg;
  logic [END_MARKER_W-1:0] em_reg;

  task automatic clear_model();
    for (int i = 0; i < WIN; i++) win_mem[i] = '0;
    wr_pos  = POS_W'(1);
    phase   = EXPECT_CTRL;
    flags   = '0;
    mask    = '0;
    hi_byte = '0;
    ended   = 1'b0;
    closed  = 1'b0;
    err     = 1'b0;
    pads    = '0;
    be_reg  = LEN_BIAS_RST;
    em_reg  = END_MARKER_RST;
    decoded_q.delete();
    fail_count = 0;
  endtask

  task automatic push_result(logic [BYTE_W-1:0] d, logic h, logic fin);
    result_t r;
    r.data = h ? d : '0;
    r.has  = h;
    r.st   = err ? ST_ERR : (ended ? ST_END : ST_RUN);
    r.fin  = fin;
    decoded_q.push_back(r);
  endtask

  // Append one byte to the history and advance the write position
  task automatic keep_byte(logic [BYTE_W-1:0] d);
    win_mem[wr_pos] = d;
    wr_pos = (int'(wr_pos) == WIN - 1) ? '0 : wr_pos + 1'b1;
  endtask

  // Pick the next item type from the remaining flags
  task automatic advance_flag();
    if (mask == '0) begin
      phase = EXPECT_CTRL;
    end else begin
      phase = ((flags & mask) != '0) ? EXPECT_LIT : EXPECT_MHI;
      mask  = mask >> 1;
    end
  endtask

  // Expand one compressed byte into its expected results
  task automatic expand_byte(logic [BYTE_W-1:0] b, logic lst);
    logic [15:0]       word;
    logic [POS_W-1:0]  mpos;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] v;
    int                count;
    if (err) begin
      push_result('0, 1'b0, 1'b1);
    end else if (ended) begin
      if (closed || pads >= PAD_LIMIT) err = 1'b1;
      else pads = pads + 1'b1;
      if (lst) closed = 1'b1;
      push_result('0, 1'b0, 1'b1);
    end else begin
      case (phase)
        EXPECT_CTRL: begin
          flags = b;
          mask  = MASK_START;
          phase = ((b & FLAG_FIRST) != '0) ? EXPECT_LIT : EXPECT_MHI;
          push_result('0, 1'b0, 1'b1);
        end
        EXPECT_LIT: begin
          keep_byte(b);
          push_result(b, 1'b1, 1'b1);
          advance_flag();
        end
        EXPECT_MHI: begin
          hi_byte = b;
          phase   = EXPECT_MLO;
          push_result('0, 1'b0, 1'b1);
        end
        default: begin
          word = {hi_byte, b};
          mpos = word[15:LEN_W];
          len  = word[LEN_W-1:0];
          if (mpos == em_reg) begin
            ended = 1'b1;
            pads  = '0;
            if (lst) closed = 1'b1;
            push_result('0, 1'b0, 1'b1);
          end else begin
            // Copy byte by byte so overlapping copies see fresh bytes
            count = int'(len) + int'(be_reg) + 1;
            for (int k = 0; k < count; k++) begin
              v = win_mem[(int'(mpos) + k) % WIN];
              keep_byte(v);
              push_result(v, 1'b1, k == count - 1);
            end
            advance_flag();
          end
        end
      endcase
    end
  endtask

  // Compare one delivered result with the oldest prediction
  task automatic check_result();
    result_t want;
    if (decoded_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: byte %h has %b status %0d last %b",
                 out_mon.out_byte, out_mon.has_byte, out_mon.status, out_mon.last);
    end else begin
      want = decoded_q.pop_front();
      if (out_mon.out_byte !== want.data || out_mon.has_byte !== want.has ||
          out_mon.status !== want.st || out_mon.last !== want.fin) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result mismatch: expected byte %h has %b status %0d last %b, %s",
                   want.data, want.has, want.st, want.fin,
                   $sformatf("got byte %h has %b status %0d last %b", out_mon.out_byte,
                             out_mon.has_byte, out_mon.status, out_mon.last));
      end
    end
  endtask

  // Check results before taking new items; a result never belongs to an item of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_LEN_BIAS:   be_reg = cfg_mon.data[LEN_BIAS_W-1:0];
          CFG_END_MARKER: em_reg = cfg_mon.data[END_MARKER_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) expand_byte(in_mon.in_byte, in_mon.in_last);
    end
    pending <= decoded_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus, receiver stalls, watchdog and verdict for the LZSS decompressor core.
module tb_top;
  import lzssd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 400;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   hold_reqs = 0;
  int   idle_cycles = 0;

  // Stream generator view of the decoder
  logic [11:0]             gen_wp = 12'd1;
  logic [LEN_BIAS_W-1:0]   be_cur = LEN_BIAS_RST;
  logic [END_MARKER_W-1:0] em_cur = END_MARKER_RST;
  int                      burst_left = 0;

  lzssd_in_if  in_ch ();
  lzssd_out_if out_ch ();
  lzssd_cfg_if cfg_ch ();

  lzss_byte_stream_decompressor_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  lzssd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one byte; open a new burst after a random gap when the last one ran out
  task automatic offer_byte(logic [7:0] b, logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic emit_literal(logic [7:0] b);
    offer_byte(b, $urandom_range(0, 7) == 0);
    gen_wp = gen_wp + 12'd1;
  endtask

  task automatic emit_match(logic [11:0] pos, logic [3:0] len);
    offer_byte(pos[11:4], $urandom_range(0, 7) == 0);
    offer_byte({pos[3:0], len}, $urandom_range(0, 7) == 0);
    gen_wp = gen_wp + 12'(len) + 12'(be_cur) + 12'd1;
  endtask

  // One control byte and the eight items it announces
  task automatic emit_random_group();
    logic [7:0]  ctrl;
    logic [11:0] pos;
    logic [3:0]  len;
    ctrl = 8'($urandom_range(0, 255));
    offer_byte(ctrl, $urandom_range(0, 7) == 0);
    for (int i = 7; i >= 0; i--) begin
      if (ctrl[i]) begin
        emit_literal(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 3))
          0: pos = gen_wp - 12'($urandom_range(1, 4));
          1: pos = gen_wp - 12'($urandom_range(1, 300));
          2: pos = 12'($urandom_range(0, 4095));
          default: pos = 12'($urandom_range(4090, 4101));
        endcase
        // Keep the marker for the end of the stream
        if (pos == em_cur) pos = pos ^ 12'd1;
        len = ($urandom_range(0, 3) == 0) ? 4'd15 : 4'($urandom_range(0, 15));
        emit_match(pos, len);
      end
    end
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic drain(int tail);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic load_config(logic [LEN_BIAS_W-1:0] be, logic [END_MARKER_W-1:0] em);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_LEN_BIAS;
    cfg_ch.data  <= CFG_DATA_W'(be);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= CFG_END_MARKER;
    cfg_ch.data  <= CFG_DATA_W'(em);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    be_cur = be;
    em_cur = em;
  endtask

  // Main stimulus
  initial begin
    logic [LEN_BIAS_W-1:0]   be;
    logic [END_MARKER_W-1:0] em;
    int                      variant;
    int                      npad;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= '0;
    in_ch.in_last  <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_LEN_BIAS;
    cfg_ch.data    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin be = 2'd0; em = 12'd4095; end
        1: begin be = 2'd3; em = 12'd0; end
        2: begin be = 2'd2; em = 12'($urandom_range(0, 4095)); end
        3: begin be = 2'd1; em = 12'($urandom_range(0, 4095)); end
        default: begin
          be = 2'($urandom_range(0, 3));
          em = 12'($urandom_range(0, 4095));
        end
      endcase
      if (ph > 0) drain(4);
      load_config(be, em);

      // Directed: byte extremes, window start and end, wrap and overlapping copies
      if (ph == 0) begin
        offer_byte(8'hF0, 1'b1);
        emit_literal(8'h00);
        emit_literal(8'hFF);
        emit_literal(8'h55);
        emit_literal(8'hAA);
        emit_match(12'd0, 4'd0);
        emit_match(12'd4094, 4'd15);
        emit_match(gen_wp - 12'd1, 4'd15);
        emit_match(gen_wp - 12'd3, 4'd7);
        offer_byte(8'h00, 1'b0);
        for (int i = 0; i < 8; i++) emit_match(gen_wp - 12'(i + 1), 4'(i * 5));
      end

      if (ph == 1 || ph == 3) hold_reqs++;
      repeat (7) emit_random_group();
    end

    // End of stream: marker, allowed padding, then bytes that trip the error
    variant = $urandom_range(0, 2);
    offer_byte(8'($urandom_range(0, 127)), 1'b0);
    offer_byte(em_cur[11:4], 1'b0);
    offer_byte({em_cur[3:0], 4'($urandom_range(0, 15))}, variant == 1);
    npad = (variant == 0) ? 3 : ((variant == 2) ? 1 : 0);
    for (int i = 0; i < npad; i++) offer_byte(8'($urandom_range(0, 255)), variant == 2);
    repeat (4) offer_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    drain(50);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Receiver: random stall patterns, free-flowing stretches and long hold-offs on request
  initial begin
    int mode;
    int span;
    int served;
    served = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (served < hold_reqs) begin
        served++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 9);
        span = $urandom_range(10, 60);
        repeat (span) begin
          if (mode < 3) out_ch.ready <= 1'b1;
          else if (mode < 8) out_ch.ready <= ($urandom_range(0, 3) != 0);
          else out_ch.ready <= ($urandom_range(0, 4) == 0);
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: count cycles in which no channel moves an item
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
